### hw/rtl/mx1_pkg.sv
`timescale 1ns / 1ps
package mx1_pkg;
    localparam int TAG_BITS_DEFAULT = 64;
    localparam int AD_MAX_BITS_DEFAULT = 64;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MSG_LONG = 2'd1;
    localparam logic [1:0] ST_AD_LONG = 2'd2;
    localparam logic [1:0] ST_NO_ROOM = 2'd3;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW = 2'd1;
    localparam logic [1:0] REG_PAD_AD = 2'd2;

    typedef struct packed {
        logic load;
        logic init1;
        logic round;
        logic last;
        logic mid;
        logic finish;
    } mx1_cmd_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction
endpackage

### hw/rtl/mx1_ctrl.sv
`timescale 1ns / 1ps
module mx1_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              err,
    output logic              busy,
    output mx1_pkg::mx1_cmd_t cmd
);
    import mx1_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INIT  = 5'b00010,
        S_RND1  = 5'b00100,
        S_RND2  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (err)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.init1 = 1'b1;
                    cnt_next = 4'd1;
                    state_next = S_RND1;
                end
            end
            S_RND1:
            begin
                cmd.round = 1'b1;
                cmd.last = (cnt_reg == 4'd10);
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd10)
                begin
                    cmd.mid = 1'b1;
                    cnt_next = 4'd1;
                    state_next = S_RND2;
                end
            end
            S_RND2:
            begin
                cmd.round = 1'b1;
                cmd.last = (cnt_reg == 4'd10);
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd10)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

### hw/rtl/mx1_datapath.sv
`timescale 1ns / 1ps
module mx1_datapath #(
    parameter int TAG_BITS = mx1_pkg::TAG_BITS_DEFAULT,
    parameter int AD_MAX_BITS = mx1_pkg::AD_MAX_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mx1_pkg::mx1_cmd_t cmd,
    input  logic [127:0]      key,
    input  logic              pad_ad,
    input  logic [127:0]      nonce,
    input  logic [7:0]        nonce_bits,
    input  logic [127:0]      ad,
    input  logic [7:0]        ad_bits,
    input  logic [127:0]      message,
    input  logic [7:0]        message_bits,
    output logic              err,
    output logic              valid,
    output logic [127:0]      cipher,
    output logic [1:0]        status
);
    import mx1_pkg::*;

    logic [127:0] n_reg, a_reg, m_reg;
    logic [7:0] nb_reg, ab_reg, mb_reg;
    logic [255:0] vstr;
    logic [127:0] s_reg, s_next, rk_reg, rk_next, l_reg, l_next, v2_reg, v2_next;
    logic [7:0] rc_reg, rc_next;
    logic [127:0] c_reg;
    logic [1:0] stat_reg;
    logic valid_reg;

    logic signed [10:0] sv, lim;
    logic [1:0] st_c;
    logic [255:0] npart, apart, mpart, padv, endv;
    logic [8:0] pos_a, pos_m, pos_e;

    always_comb
    begin
        sv = 11'sd128 - $signed({3'b0, nb_reg}) + 11'(TAG_BITS);
        if (sv < 11'(AD_MAX_BITS))
        begin
            sv = 11'(AD_MAX_BITS);
        end
        lim = 11'sd256 - sv - $signed({3'b0, nb_reg});
        if ({3'b0, mb_reg} >= 11'(128 - TAG_BITS))
        begin
            st_c = ST_MSG_LONG;
        end
        else if ({3'b0, ab_reg} > 11'(AD_MAX_BITS))
        begin
            st_c = ST_AD_LONG;
        end
        else if ($signed({3'b0, mb_reg}) >= lim)
        begin
            st_c = ST_NO_ROOM;
        end
        else
        begin
            st_c = ST_OK;
        end
    end
    assign err = (st_c != ST_OK);

    function automatic logic [255:0] mask_top(input logic [127:0] d, input logic [7:0] n);
        logic [127:0] mk;
        mk = (n >= 8'd128) ? '1 : ~('1 >> n);
        return {d & mk, 128'b0};
    endfunction

    always_comb
    begin
        pos_a = {1'b0, nb_reg};
        pos_m = pos_a + {1'b0, ab_reg};
        if (pad_ad)
        begin
            pos_m = pos_a + sv[8:0];
        end
        pos_e = pos_m + {1'b0, mb_reg};
        npart = mask_top(n_reg, nb_reg);
        apart = mask_top(a_reg, ab_reg) >> pos_a;
        mpart = mask_top(m_reg, mb_reg) >> pos_m;
        padv = pad_ad ? ({1'b1, 255'b0} >> (pos_a + {1'b0, ab_reg})) : '0;
        endv = {1'b1, 255'b0} >> pos_e[7:0];
    end

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0] t [16];
        logic [7:0] o [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            t[i] = sbox(s[127-8*i -: 8]);
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                o[i+4*c] = t[i+4*((c+i)%4)];
            end
        end
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                o[4*c] = a0 ^ al ^ xt(a0 ^ a1);
                o[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
                o[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
                o[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            r[127-8*i -: 8] = o[i] ^ rk[127-8*i -: 8];
        end
        return r;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] dbl(input logic [127:0] p);
        logic [127:0] le, r;
        for (int i = 0; i < 16; i++)
        begin
            le[8*i +: 8] = p[127-8*i -: 8];
        end
        le = {le[126:0], 1'b0} ^ (le[127] ? 128'h87 : 128'h0);
        for (int i = 0; i < 16; i++)
        begin
            r[127-8*i -: 8] = le[8*i +: 8];
        end
        return r;
    endfunction

    logic [127:0] rk_new, s_rnd;
    assign rk_new = key_step(rk_reg, rc_reg);
    assign s_rnd = aes_round(s_reg, rk_new, cmd.last);

    always_comb
    begin
        vstr = npart | apart | padv | mpart | endv;
        s_next = s_reg;
        rk_next = rk_reg;
        rc_next = rc_reg;
        l_next = l_reg;
        v2_next = v2_reg;
        if (cmd.init1)
        begin
            s_next = vstr[255:128] ^ key;
            v2_next = vstr[127:0];
            rk_next = key;
            rc_next = 8'h01;
        end
        else if (cmd.round)
        begin
            s_next = s_rnd;
            rk_next = rk_new;
            rc_next = xt(rc_reg);
            if (cmd.mid)
            begin
                l_next = dbl(s_rnd);
                s_next = v2_reg ^ dbl(s_rnd) ^ key;
                rk_next = key;
                rc_next = 8'h01;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= nonce; a_reg <= ad; m_reg <= message;
            nb_reg <= nonce_bits; ab_reg <= ad_bits; mb_reg <= message_bits;
        end
        s_reg <= s_next;
        rk_reg <= rk_next;
        rc_reg <= rc_next;
        l_reg <= l_next;
        v2_reg <= v2_next;
        if (cmd.finish)
        begin
            c_reg <= err ? '0 : (s_reg ^ l_reg);
            stat_reg <= err ? st_c : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.finish;
        end
    end

    assign valid = valid_reg;
    assign cipher = c_reg;
    assign status = stat_reg;
endmodule

### hw/rtl/manx1_aes128_encrypt.sv
`timescale 1ns / 1ps
// Short-message authenticated encryption built from two chained AES-128 passes.
// Configure key_high, key_low and pad_associated_data through the write port
// (cfg_we, cfg_index, cfg_data) while the block is idle.
// A transaction starts at a clock edge with start high and busy low; the nonce,
// associated data and message fields with their bit counts are captured then.
// Length checks run in the first cycle after start. A failed check returns
// zero ciphertext and a nonzero status. Otherwise the two encryptions run
// one AES round per cycle from a shared round unit and key expander.
// The block takes a new transaction at the clock edge that ends the result
// strobe. The result holds for one cycle, marked by done; the receiver cannot stall.
// Reset clears the keys, sets padding on and returns the block to idle.
module manx1_aes128_encrypt #(
    parameter int TAG_BITS = mx1_pkg::TAG_BITS_DEFAULT,
    parameter int AD_MAX_BITS = mx1_pkg::AD_MAX_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] nonce_high,
    input  logic [63:0] nonce_low,
    input  logic [7:0]  nonce_bits,
    input  logic [63:0] ad_high,
    input  logic [63:0] ad_low,
    input  logic [7:0]  ad_bits,
    input  logic [63:0] message_high,
    input  logic [63:0] message_low,
    input  logic [7:0]  message_bits,
    output logic        done,
    output logic [63:0] cipher_high,
    output logic [63:0] cipher_low,
    output logic [1:0]  status
);
    import mx1_pkg::*;

    logic [63:0] kh_reg, kl_reg;
    logic pad_reg;
    mx1_cmd_t cmd;
    logic err;
    logic [127:0] cipher;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kh_reg <= '0;
            kl_reg <= '0;
            pad_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_HIGH: kh_reg <= cfg_data;
                REG_KEY_LOW: kl_reg <= cfg_data;
                REG_PAD_AD: pad_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mx1_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .err(err), .busy(busy), .cmd(cmd)
    );

    mx1_datapath #(.TAG_BITS(TAG_BITS), .AD_MAX_BITS(AD_MAX_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .key({kh_reg, kl_reg}), .pad_ad(pad_reg),
        .nonce({nonce_high, nonce_low}), .nonce_bits(nonce_bits),
        .ad({ad_high, ad_low}), .ad_bits(ad_bits),
        .message({message_high, message_low}), .message_bits(message_bits),
        .err(err), .valid(done), .cipher(cipher), .status(status)
    );

    assign cipher_high = cipher[127:64];
    assign cipher_low = cipher[63:0];
endmodule

### dv/tb_manx1_aes128_encrypt.sv
`timescale 1ns / 1ps
module tb_manx1_aes128_encrypt;
    import mx1_pkg::*;

    localparam int TAG_W = 64;
    localparam int AD_MAX = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_PER_PHASE = 235;

    localparam logic [7:0] SUB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    typedef struct packed {
        logic [63:0] n_hi;
        logic [63:0] n_lo;
        logic [7:0]  n_len;
        logic [63:0] a_hi;
        logic [63:0] a_lo;
        logic [7:0]  a_len;
        logic [63:0] m_hi;
        logic [63:0] m_lo;
        logic [7:0]  m_len;
    } msg_item_t;

    typedef struct packed {
        logic [63:0] c_hi;
        logic [63:0] c_lo;
        logic [1:0]  st;
    } cipher_res_t;

    typedef struct packed {
        msg_item_t   item;
        logic        typed;
        cipher_res_t res;
    } vector_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        start;
    logic        busy;
    logic [63:0] nonce_high, nonce_low, ad_high, ad_low, message_high, message_low;
    logic [7:0]  nonce_bits, ad_bits, message_bits;
    logic        done;
    logic [63:0] cipher_high, cipher_low;
    logic [1:0]  status;

    logic [127:0] cur_key;
    logic         cur_pad;
    cipher_res_t  cipher_expected[$];
    int           errors;
    int           cycles;

    manx1_aes128_encrypt dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy),
        .nonce_high(nonce_high), .nonce_low(nonce_low), .nonce_bits(nonce_bits),
        .ad_high(ad_high), .ad_low(ad_low), .ad_bits(ad_bits),
        .message_high(message_high), .message_low(message_low),
        .message_bits(message_bits), .done(done), .cipher_high(cipher_high),
        .cipher_low(cipher_low), .status(status)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [7:0] times2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_block(input logic [127:0] blk, input logic [127:0] key);
        logic [7:0] st [16];
        logic [7:0] rk [16];
        logic [7:0] tmp [16];
        logic [7:0] t [4];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[127 - 8 * i -: 8];
            st[i] = blk[127 - 8 * i -: 8] ^ rk[i];
        end
        for (int r = 1; r <= 10; r++)
        begin
            for (int i = 0; i < 16; i++)
                tmp[i] = SUB[st[i]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    st[i + 4 * c] = tmp[i + 4 * ((c + i) & 3)];
            if (r < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[4 * c];
                    a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2];
                    a3 = st[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4 * c] = a0 ^ all ^ times2(a0 ^ a1);
                    st[4 * c + 1] = a1 ^ all ^ times2(a1 ^ a2);
                    st[4 * c + 2] = a2 ^ all ^ times2(a2 ^ a3);
                    st[4 * c + 3] = a3 ^ all ^ times2(a3 ^ a0);
                end
            end
            t[0] = SUB[rk[13]] ^ rc;
            t[1] = SUB[rk[14]];
            t[2] = SUB[rk[15]];
            t[3] = SUB[rk[12]];
            for (int i = 0; i < 4; i++)
                rk[i] = rk[i] ^ t[i];
            for (int i = 4; i < 16; i++)
                rk[i] = rk[i] ^ rk[i - 4];
            rc = times2(rc);
            for (int i = 0; i < 16; i++)
                st[i] = st[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    function automatic logic [127:0] gf_double(input logic [127:0] blk);
        logic [7:0] p [16];
        logic top;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
            p[i] = blk[127 - 8 * i -: 8];
        top = p[15][7];
        for (int i = 15; i > 0; i--)
            p[i] = {p[i][6:0], p[i - 1][7]};
        p[0] = {p[0][6:0], 1'b0};
        if (top)
            p[0] = p[0] ^ 8'h87;
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = p[i];
        return res;
    endfunction

    function automatic int place_bits(inout logic [255:0] v, input int pos,
                                      input logic [127:0] src, input int len);
        for (int i = 0; i < len && i < 128; i++)
            if (src[127 - i])
                v[255 - ((pos + i) & 255)] = 1'b1;
        return pos + len;
    endfunction

    function automatic cipher_res_t predict_cipher(input msg_item_t it);
        cipher_res_t res;
        int nl, al, ml, s, pos;
        logic [255:0] v;
        logic [127:0] l, c;
        nl = int'(it.n_len);
        al = int'(it.a_len);
        ml = int'(it.m_len);
        s = 128 - nl + TAG_W;
        if (s < AD_MAX)
            s = AD_MAX;
        res = '0;
        if (ml >= 128 - TAG_W)
            res.st = ST_MSG_LONG;
        else if (al > AD_MAX)
            res.st = ST_AD_LONG;
        else if (ml >= 256 - s - nl)
            res.st = ST_NO_ROOM;
        else
            res.st = ST_OK;
        if (res.st != ST_OK)
            return res;
        v = '0;
        pos = place_bits(v, 0, {it.n_hi, it.n_lo}, nl);
        pos = place_bits(v, pos, {it.a_hi, it.a_lo}, al);
        if (cur_pad)
        begin
            v[255 - (pos & 255)] = 1'b1;
            pos = pos + s - al;
        end
        pos = place_bits(v, pos, {it.m_hi, it.m_lo}, ml);
        v[255 - (pos & 255)] = 1'b1;
        l = gf_double(aes_block(v[255:128], cur_key));
        c = aes_block(v[127:0] ^ l, cur_key) ^ l;
        res.c_hi = c[127:64];
        res.c_lo = c[63:0];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic msg_item_t random_item();
        msg_item_t it;
        it.n_hi = rand64();
        it.n_lo = rand64();
        it.a_hi = rand64();
        it.a_lo = rand64();
        it.m_hi = rand64();
        it.m_lo = rand64();
        if ($urandom_range(0, 9) < 8)
        begin
            it.n_len = 8'($urandom_range(0, 128));
            it.a_len = 8'($urandom_range(0, 64));
            it.m_len = 8'($urandom_range(0, 63));
        end
        else
        begin
            it.n_len = 8'($urandom_range(0, 255));
            it.a_len = 8'($urandom_range(0, 255));
            it.m_len = 8'($urandom_range(0, 255));
        end
        return it;
    endfunction

    function automatic int pick_gap(input bit quiet);
        if (quiet)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == REG_KEY_HIGH)
            cur_key[127:64] = data;
        else if (idx == REG_KEY_LOW)
            cur_key[63:0] = data;
        else if (idx == REG_PAD_AD)
            cur_pad = data[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (cipher_expected.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic send_item(input vector_t vec, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        nonce_high <= vec.item.n_hi;
        nonce_low <= vec.item.n_lo;
        nonce_bits <= vec.item.n_len;
        ad_high <= vec.item.a_hi;
        ad_low <= vec.item.a_lo;
        ad_bits <= vec.item.a_len;
        message_high <= vec.item.m_hi;
        message_low <= vec.item.m_lo;
        message_bits <= vec.item.m_len;
        do
            @(posedge clk);
        while (busy);
        if (vec.typed)
            cipher_expected.push_back(vec.res);
        else
            cipher_expected.push_back(predict_cipher(vec.item));
    endtask

    task automatic random_phase(input int count);
        vector_t vec;
        bit quiet;
        for (int k = 0; k < count; k++)
        begin
            if (k % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            vec.item = random_item();
            vec.typed = 1'b0;
            vec.res = '0;
            send_item(vec, pick_gap(quiet));
        end
        wait_idle();
    endtask

    function automatic vector_t row(input logic [7:0] nl, input logic [7:0] al,
                                    input logic [7:0] ml, input logic ones,
                                    input logic typed, input logic [1:0] st);
        vector_t vec;
        logic [63:0] f;
        f = ones ? 64'hffff_ffff_ffff_ffff : 64'h0;
        vec.item = '{f, f, nl, f, f, al, f, f, ml};
        vec.typed = typed;
        vec.res = '{64'h0, 64'h0, st};
        return vec;
    endfunction

    vector_t directed [];

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        cipher_res_t ex;
        if (rst_n && done)
        begin
            if (cipher_expected.size() == 0)
            begin
                $display("%0t: result with nothing expected: %h %h %0d", $time,
                         cipher_high, cipher_low, status);
                errors++;
            end
            else
            begin
                ex = cipher_expected.pop_front();
                if (status !== ex.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, ex.st, status);
                    errors++;
                end
                if (cipher_high !== ex.c_hi)
                begin
                    $display("%0t: cipher_high expected %h actual %h", $time, ex.c_hi,
                             cipher_high);
                    errors++;
                end
                if (cipher_low !== ex.c_lo)
                begin
                    $display("%0t: cipher_low expected %h actual %h", $time, ex.c_lo,
                             cipher_low);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        cur_key = '0;
        cur_pad = 1'b1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = '0;
        start = 1'b0;
        {nonce_high, nonce_low, ad_high, ad_low, message_high, message_low} = '0;
        {nonce_bits, ad_bits, message_bits} = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            row(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, ST_OK),
            row(8'd0, 8'd0, 8'd0, 1'b1, 1'b0, ST_OK),
            row(8'd128, 8'd64, 8'd63, 1'b1, 1'b0, ST_OK),
            row(8'd128, 8'd64, 8'd0, 1'b0, 1'b0, ST_OK),
            row(8'd96, 8'd64, 8'd63, 1'b1, 1'b0, ST_OK),
            row(8'd1, 8'd1, 8'd1, 1'b1, 1'b0, ST_OK),
            row(8'd127, 8'd0, 8'd63, 1'b1, 1'b0, ST_OK),
            row(8'd129, 8'd0, 8'd62, 1'b1, 1'b0, ST_OK),
            row(8'd160, 8'd32, 8'd31, 1'b1, 1'b0, ST_OK),
            row(8'd0, 8'd0, 8'd64, 1'b1, 1'b1, ST_MSG_LONG),
            row(8'd0, 8'd0, 8'd255, 1'b1, 1'b1, ST_MSG_LONG),
            row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, ST_MSG_LONG),
            row(8'd0, 8'd65, 8'd0, 1'b1, 1'b1, ST_AD_LONG),
            row(8'd0, 8'd255, 8'd63, 1'b1, 1'b1, ST_AD_LONG),
            row(8'd129, 8'd0, 8'd63, 1'b1, 1'b1, ST_NO_ROOM),
            row(8'd200, 8'd0, 8'd0, 1'b1, 1'b1, ST_NO_ROOM),
            row(8'd255, 8'd64, 8'd0, 1'b0, 1'b1, ST_NO_ROOM)
        };
        foreach (directed[i])
            send_item(directed[i], pick_gap(1'b0));
        wait_idle();

        write_reg(REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_PAD_AD, 64'h0);
        foreach (directed[i])
            send_item(directed[i], pick_gap(1'b0));
        random_phase(RANDOM_PER_PHASE);

        write_reg(REG_KEY_HIGH, rand64());
        write_reg(REG_KEY_LOW, rand64());
        write_reg(REG_PAD_AD, 64'h1);
        random_phase(RANDOM_PER_PHASE);

        write_reg(REG_KEY_LOW, rand64());
        write_reg(REG_PAD_AD, 64'hffff_ffff_ffff_fffe);
        random_phase(RANDOM_PER_PHASE);

        write_reg(REG_KEY_HIGH, 64'h0);
        write_reg(REG_KEY_LOW, 64'h0);
        write_reg(REG_PAD_AD, 64'h1);
        random_phase(RANDOM_PER_PHASE);

        if (errors == 0 && cipher_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### manx1_aes128_encrypt.f
hw/rtl/mx1_pkg.sv
hw/rtl/mx1_ctrl.sv
hw/rtl/mx1_datapath.sv
hw/rtl/manx1_aes128_encrypt.sv
dv/tb_manx1_aes128_encrypt.sv
